@@ hw/rtl/hhpd_pkg.sv @@
// ----------------------------------------------------------------------------
// hhpd_pkg: shared types and constants of the heading-hold drive controller
// Request and result layouts, register map, sequencer states and the fixed
// constants of the angle wrap and the turn accumulator.
// ----------------------------------------------------------------------------
package hhpd_pkg;

	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 3;

	// Register map
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_P_GAIN     = 3'd0,
		CFG_I_GAIN     = 3'd1,
		CFG_D_GAIN     = 3'd2,
		CFG_LOOP_SCALE = 3'd3,
		CFG_SMOOTHING  = 3'd4
	} cfg_idx_t;

	localparam logic [CFG_W-1:0] P_GAIN_RST     = 16'd256;
	localparam logic [CFG_W-1:0] I_GAIN_RST     = 16'd13;
	localparam logic [CFG_W-1:0] D_GAIN_RST     = 16'd512;
	localparam logic [CFG_W-1:0] LOOP_SCALE_RST = 16'd66;
	localparam logic [CFG_W-1:0] SMOOTHING_RST  = 16'd32768;

	typedef struct packed {
		logic [CFG_W-1:0] p_gain;
		logic [CFG_W-1:0] i_gain;
		logic [CFG_W-1:0] d_gain;
		logic [CFG_W-1:0] loop_scale;
		logic [CFG_W-1:0] smoothing_gain;
	} cfg_t;

	// Request kinds
	localparam logic KIND_STEP  = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	typedef struct packed {
		logic               kind;
		logic signed [23:0] target_angle;
		logic signed [23:0] heading;
		logic signed [19:0] turn_rate;
		logic signed [15:0] drive_demand;
	} req_t;

	typedef struct packed {
		logic signed [15:0] left_drive;
		logic signed [15:0] right_drive;
		logic signed [15:0] turn_power;
	} rsp_t;

	// Datapath widths
	localparam int unsigned REM_W  = 25;
	localparam int unsigned ERR_W  = 18;
	localparam int unsigned ACC_W  = 50;
	localparam int unsigned ACCC_W = 42;
	localparam int unsigned PROD_W = 58;
	localparam int unsigned LAG_W  = 35;

	// Angle constants, 1/256 degree
	localparam logic [REM_W-1:0]        ANGLE_FULL = 25'd92160;
	localparam logic [REM_W-1:0]        WRAP_BIAS  = 25'd23592960; // 256 full turns
	localparam logic signed [ERR_W-1:0] ERR_FULL   = 18'sd92160;
	localparam logic signed [ERR_W-1:0] ERR_HALF   = 18'sd46080;

	localparam logic signed [ACC_W-1:0] ACC_LIMIT = 50'sh100_0000_0000;

	// Sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRAP,
		ST_INTEG,
		ST_MAC,
		ST_SCALE,
		ST_POST,
		ST_CLEAR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       load;
		logic       wrap_step;
		logic       integ;
		logic       mac_step;
		logic       scale_step;
		logic       post;
		logic       clear;
		logic [3:0] bit_idx;
	} ctrl_t;

	// Full turn scaled by a power of two, for the restoring wrap steps
	function automatic logic [REM_W-1:0] wrap_mod(input logic [2:0] k);
		logic [REM_W-1:0] m;
		m = ANGLE_FULL << k;
		return m;
	endfunction

endpackage

@@ hw/rtl/hhpd_ctrl.sv @@
// ----------------------------------------------------------------------------
// hhpd_ctrl: step sequencer
// Walks a step request through wrap, integrate, multiply-accumulate, scale
// and post phases, a clear through a clear phase, with a shared bit counter.
// ----------------------------------------------------------------------------
module hhpd_ctrl import hhpd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  logic  kind,
	input  logic  out_free,
	output ctrl_t ctrl,
	output logic  busy,
	output logic  res_load
);

	state_t     state_q, state_d;
	logic [3:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (kind == KIND_CLEAR) ? ST_CLEAR : ST_WRAP;
				end
			end
			ST_WRAP: begin
				if (cnt_q == 4'd7) begin
					state_d = ST_INTEG;
				end
			end
			ST_INTEG: state_d = ST_MAC;
			ST_MAC: begin
				if (cnt_q == 4'd15) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				if (cnt_q == 4'd15) begin
					state_d = ST_POST;
				end
			end
			ST_POST:  state_d = ST_DONE;
			ST_CLEAR: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		// restart the bit counter on every phase change
		cnt_d = (state_d != state_q) ? 4'd0 : cnt_q + 4'd1;
	end

	always_comb begin
		ctrl            = '0;
		ctrl.load       = (state_q == ST_IDLE) && accept;
		ctrl.wrap_step  = (state_q == ST_WRAP);
		ctrl.integ      = (state_q == ST_INTEG);
		ctrl.mac_step   = (state_q == ST_MAC);
		ctrl.scale_step = (state_q == ST_SCALE);
		ctrl.post       = (state_q == ST_POST);
		ctrl.clear      = (state_q == ST_CLEAR);
		ctrl.bit_idx    = ~cnt_q;
		busy            = (state_q != ST_IDLE);
		res_load        = (state_q == ST_DONE) && out_free;
	end

endmodule

@@ hw/rtl/hhpd_wrap.sv @@
// ----------------------------------------------------------------------------
// hhpd_wrap: heading error wrap
// Reduces target minus heading modulo a full turn with one restoring
// compare-subtract per cycle, then folds into (-180, +180] degrees.
// ----------------------------------------------------------------------------
module hhpd_wrap import hhpd_pkg::*; (
	input  logic                     clk,
	input  ctrl_t                    ctrl,
	input  logic signed [23:0]       target_angle,
	input  logic signed [23:0]       heading,
	output logic signed [ERR_W-1:0]  err
);

	logic [REM_W-1:0]        rem_q;
	logic signed [25:0]      diff;
	logic [REM_W-1:0]        m;
	logic signed [ERR_W-1:0] rem_s;

	assign diff = 26'(target_angle) - 26'(heading);
	assign m    = wrap_mod(ctrl.bit_idx[2:0]);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			// bias negative differences by whole turns so the remainder starts positive
			rem_q <= diff[25] ? diff[REM_W-1:0] + WRAP_BIAS : diff[REM_W-1:0];
		end else if (ctrl.wrap_step && (rem_q >= m)) begin
			rem_q <= rem_q - m;
		end
	end

	assign rem_s = {1'b0, rem_q[ERR_W-2:0]};
	assign err   = (rem_s > ERR_HALF) ? rem_s - ERR_FULL : rem_s;

endmodule

@@ hw/rtl/hhpd_dp.sv @@
// ----------------------------------------------------------------------------
// hhpd_dp: controller datapath
// Saturating integrator, bit-serial PID and lag multipliers, loop scaling
// and the side mix of the drive commands.
// ----------------------------------------------------------------------------
module hhpd_dp import hhpd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ctrl_t                   ctrl,
	input  cfg_t                    cfg,
	input  req_t                    req,
	input  logic signed [ERR_W-1:0] err,
	output rsp_t                    result
);

	logic signed [19:0]       rate_q;
	logic signed [15:0]       demand_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [31:0]       sum_q;
	logic signed [15:0]       smooth_q;
	logic signed [15:0]       turn_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [LAG_W-1:0]  lag_q;
	logic signed [PROD_W-1:0] prod_q;

	logic signed [32:0]       sum_ext;
	logic signed [31:0]       sum_sat;
	logic signed [ACC_W-1:0]  p_term, i_term, d_term;
	logic signed [16:0]       lag_diff;
	logic signed [LAG_W-1:0]  lag_term;
	logic signed [ACCC_W-1:0] acc_clamp;
	logic signed [PROD_W-1:0] prod_term;
	logic signed [PROD_W-1:0] prod_rnd;
	logic signed [40:0]       turn_full;
	logic signed [15:0]       turn_sat;
	logic signed [LAG_W-1:0]  lag_rnd;
	logic signed [18:0]       lag_q16;
	logic signed [19:0]       smooth_full;
	logic signed [15:0]       smooth_sat;
	logic signed [17:0]       left_full, right_full;

	// integrator, saturating at the 32-bit limits
	always_comb begin
		sum_ext = 33'(sum_q) + 33'(err);
		if (sum_ext[32] != sum_ext[31]) begin
			sum_sat = sum_ext[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			sum_sat = sum_ext[31:0];
		end
	end

	// one gain bit per cycle, most significant first
	always_comb begin
		p_term    = cfg.p_gain[ctrl.bit_idx] ? ACC_W'(err_q) : '0;
		i_term    = cfg.i_gain[ctrl.bit_idx] ? ACC_W'(sum_q) : '0;
		d_term    = cfg.d_gain[ctrl.bit_idx] ? ACC_W'(rate_q) : '0;
		lag_diff  = 17'(demand_q) - 17'(smooth_q);
		lag_term  = cfg.smoothing_gain[ctrl.bit_idx] ? LAG_W'(lag_diff) : '0;
		if (acc_q > ACC_LIMIT) begin
			acc_clamp = ACCC_W'(ACC_LIMIT);
		end else if (acc_q < -ACC_LIMIT) begin
			acc_clamp = ACCC_W'(-ACC_LIMIT);
		end else begin
			acc_clamp = ACCC_W'(acc_q);
		end
		prod_term = cfg.loop_scale[ctrl.bit_idx] ? PROD_W'(acc_clamp) : '0;
	end

	// round to nearest, ties up, then clamp turn and lag update
	always_comb begin
		prod_rnd  = prod_q + PROD_W'(65536);
		turn_full = 41'(prod_rnd >>> 17);
		if (turn_full > 41'sd32767) begin
			turn_sat = 16'sh7fff;
		end else if (turn_full < -41'sd32768) begin
			turn_sat = 16'sh8000;
		end else begin
			turn_sat = turn_full[15:0];
		end
		lag_rnd     = lag_q + LAG_W'(32768);
		lag_q16     = 19'(lag_rnd >>> 16);
		smooth_full = 20'(smooth_q) + 20'(lag_q16);
		if (smooth_full > 20'sd32767) begin
			smooth_sat = 16'sh7fff;
		end else if (smooth_full < -20'sd32768) begin
			smooth_sat = 16'sh8000;
		end else begin
			smooth_sat = smooth_full[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			smooth_q <= '0;
		end else if (ctrl.clear) begin
			sum_q    <= '0;
			smooth_q <= '0;
		end else begin
			if (ctrl.integ) begin
				sum_q <= sum_sat;
			end
			if (ctrl.post) begin
				smooth_q <= smooth_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rate_q   <= req.turn_rate;
			demand_q <= req.drive_demand;
		end
		if (ctrl.integ) begin
			err_q  <= err;
			acc_q  <= '0;
			lag_q  <= '0;
			prod_q <= '0;
		end
		if (ctrl.mac_step) begin
			acc_q <= (acc_q <<< 1) + p_term + i_term - d_term;
			lag_q <= (lag_q <<< 1) + lag_term;
		end
		if (ctrl.scale_step) begin
			prod_q <= (prod_q <<< 1) + prod_term;
		end
		if (ctrl.post) begin
			turn_q <= turn_sat;
		end else if (ctrl.clear) begin
			turn_q <= '0;
		end
	end

	// side mix
	always_comb begin
		left_full  = 18'(turn_q) - 18'(smooth_q);
		right_full = 18'(smooth_q) + 18'(turn_q);
		result.turn_power = turn_q;
		if (left_full > 18'sd32767) begin
			result.left_drive = 16'sh7fff;
		end else if (left_full < -18'sd32768) begin
			result.left_drive = 16'sh8000;
		end else begin
			result.left_drive = left_full[15:0];
		end
		if (right_full > 18'sd32767) begin
			result.right_drive = 16'sh7fff;
		end else if (right_full < -18'sd32768) begin
			result.right_drive = 16'sh8000;
		end else begin
			result.right_drive = right_full[15:0];
		end
	end

endmodule

@@ hw/rtl/heading_hold_pid_drive.sv @@
// ----------------------------------------------------------------------------
// heading_hold_pid_drive: heading-hold PID controller for a two-sided drive
// Wraps the heading error, integrates it, forms the scaled PID turn power,
// smooths the drive demand and mixes both into left and right commands.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------------------
//   req      | req_valid / req_stall | req_data  (kind, angles, rate, demand)
//   rsp      | rsp_valid / rsp_stall | rsp_data  (left, right, turn power)
//   cfg      | cfg_we                | cfg_index, cfg_data (no read-back)
//
// A control request runs from acceptance to a loaded result through 8 wrap
// steps, 1 integrate, 16 PID bit steps and 16 loop-scale bit steps (one gain
// bit per cycle), 1 round and 1 output load; a clear request runs a clear
// step and an output load. A new request is taken only once the previous
// one has left the sequencer. Reset restores the register defaults and
// zeroes the integrator and the drive filter. A new request is taken while a
// result waits under rsp_stall; that request holds in its last cycle until
// the output register frees up.
// ----------------------------------------------------------------------------
module heading_hold_pid_drive import hhpd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp_data
);

	cfg_t                    cfg_q;
	ctrl_t                   ctrl;
	logic                    busy;
	logic                    res_load;
	logic                    accept;
	logic                    out_free;
	logic signed [ERR_W-1:0] err;
	rsp_t                    result;
	logic                    rsp_valid_q;
	rsp_t                    rsp_data_q;

	// register file; writes past the map drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.p_gain         <= P_GAIN_RST;
			cfg_q.i_gain         <= I_GAIN_RST;
			cfg_q.d_gain         <= D_GAIN_RST;
			cfg_q.loop_scale     <= LOOP_SCALE_RST;
			cfg_q.smoothing_gain <= SMOOTHING_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_P_GAIN:     cfg_q.p_gain         <= cfg_data;
				CFG_I_GAIN:     cfg_q.i_gain         <= cfg_data;
				CFG_D_GAIN:     cfg_q.d_gain         <= cfg_data;
				CFG_LOOP_SCALE: cfg_q.loop_scale     <= cfg_data;
				CFG_SMOOTHING:  cfg_q.smoothing_gain <= cfg_data;
				default: ;
			endcase
		end
	end

	// one request in flight; stall while the sequencer is busy
	assign req_stall = busy;
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	hhpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.kind     (req_data.kind),
		.out_free (out_free),
		.ctrl     (ctrl),
		.busy     (busy),
		.res_load (res_load)
	);

	hhpd_wrap u_wrap (
		.clk          (clk),
		.ctrl         (ctrl),
		.target_angle (req_data.target_angle),
		.heading      (req_data.heading),
		.err          (err)
	);

	hhpd_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.cfg    (cfg_q),
		.req    (req_data),
		.err    (err),
		.result (result)
	);

	// output register: load when free, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			rsp_data_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

endmodule

@@ dv/heading_hold_pid_drive_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heading_hold_pid_drive_tb: self-checking bench for the heading-hold drive
// Sends control and clear requests through the valid/stall handshake. Each
// accepted request is run through a cycle-free model of the wrap, integrator,
// PID, loop scale, drive lag and side mix, and the result is queued. Every
// accepted result is compared field by field with the oldest queued result.
// Register settings move between defaults, both extremes, spare indexes and
// random gains. Both sides insert random idle bursts in most phases, not the last.
// ----------------------------------------------------------------------------
module heading_hold_pid_drive_tb;
	import hhpd_pkg::*;

	// Angle wrap and saturation limits of the model
	localparam longint TURN_FULL = 92160;
	localparam longint TURN_HALF = 46080;
	localparam longint SUM_MAX   = 64'sd2147483647;
	localparam longint SUM_MIN   = -SUM_MAX - 1;
	localparam longint MAC_LIMIT = 64'sd1 <<< 40;
	localparam longint CMD_MAX   = 32767;
	localparam longint CMD_MIN   = -32768;

	// Field extremes of a request
	localparam int ANG_MAX  = 8388607;
	localparam int ANG_MIN  = -8388608;
	localparam int RATE_MAX = 524287;
	localparam int RATE_MIN = -524288;
	localparam int DEM_MAX  = 32767;
	localparam int DEM_MIN  = -32768;

	// Indexes past the register map; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_FIRST = 3'd5;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LAST  = 3'd7;

	localparam int GAIN_PHASES = 8;
	localparam int PHASE_ITEMS = 170;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req_data = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp_data;

	// Model state: register copy, integrator and drive lag
	cfg_t   model_gains = '{P_GAIN_RST, I_GAIN_RST, D_GAIN_RST, LOOP_SCALE_RST, SMOOTHING_RST};
	longint model_integral = 0;
	longint model_lag = 0;

	rsp_t   predicted_cmds[$];

	int idle_pct = 0;     // chance in percent of an idle burst per opportunity
	int stall_left = 0;
	int drift_sign = 1;   // preferred sign of the heading error in drift runs
	int fail_count = 0;
	int sent_count = 0;
	int clear_count = 0;
	int checked_count = 0;
	int write_count = 0;

	heading_hold_pid_drive dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#15_000_000;
		$display("[heading_hold_pid_drive] ERROR");
		$finish;
	end

	function automatic longint clip(input longint x, input longint lo, input longint hi);
		if (x < lo) return lo;
		if (x > hi) return hi;
		return x;
	endfunction

	// Advance the model by one request and return the command it must produce
	function automatic rsp_t predict_drive(input req_t r);
		longint diff, err, acc, turn, lag_delta, left, right;
		rsp_t   cmd;
		cmd = '0;
		if (r.kind == KIND_CLEAR) begin
			model_integral = 0;
			model_lag = 0;
			return cmd;
		end
		// Wrap the error into (-180, +180] degrees; minus half a turn lands on plus
		diff = longint'($signed(r.target_angle)) - longint'($signed(r.heading));
		err = diff % TURN_FULL;
		if (err < 0) err += TURN_FULL;
		if (err > TURN_HALF) err -= TURN_FULL;
		model_integral = clip(model_integral + err, SUM_MIN, SUM_MAX);
		acc = longint'(model_gains.p_gain) * err
			+ longint'(model_gains.i_gain) * model_integral
			- longint'(model_gains.d_gain) * longint'($signed(r.turn_rate));
		acc = clip(acc, -MAC_LIMIT, MAC_LIMIT);
		// Round to nearest, ties up: arithmetic shift floors
		turn = (acc * longint'(model_gains.loop_scale) + (64'sd1 <<< 16)) >>> 17;
		turn = clip(turn, CMD_MIN, CMD_MAX);
		lag_delta = (longint'(model_gains.smoothing_gain)
			* (longint'($signed(r.drive_demand)) - model_lag) + (64'sd1 <<< 15)) >>> 16;
		model_lag = clip(model_lag + lag_delta, CMD_MIN, CMD_MAX);
		left = clip(turn - model_lag, CMD_MIN, CMD_MAX);
		right = clip(model_lag + turn, CMD_MIN, CMD_MAX);
		cmd.left_drive = 16'(left);
		cmd.right_drive = 16'(right);
		cmd.turn_power = 16'(turn);
		return cmd;
	endfunction

	function automatic req_t make_step(input int tgt, input int hdg, input int rate,
		input int dem);
		req_t r;
		r.kind = KIND_STEP;
		r.target_angle = 24'(tgt);
		r.heading = 24'(hdg);
		r.turn_rate = 20'(rate);
		r.drive_demand = 16'(dem);
		return r;
	endfunction

	// Clear with junk in every other field; the block must ignore it
	function automatic req_t make_clear();
		req_t r;
		r = make_step($urandom, $urandom, $urandom, $urandom);
		r.kind = KIND_CLEAR;
		return r;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int   tgt, hdg, rate, dem, half;
		tgt = int'($signed(24'($urandom)));
		half = $urandom_range(0, 1) ? 46080 : -46080;
		case ($urandom_range(0, 3))
			0: hdg = tgt + int'($urandom_range(0, 4000)) - 2000;
			1: hdg = int'($signed(24'($urandom)));
			// Hug the half-turn boundary, up to three full turns away
			2: hdg = tgt - half + int'($urandom_range(0, 4)) - 2
				+ (int'($urandom_range(0, 6)) - 3) * 92160;
			// Same-sign error so the integrator builds up
			default: hdg = tgt - drift_sign * int'($urandom_range(20000, 46080));
		endcase
		case ($urandom_range(0, 9))
			0: rate = $urandom_range(0, 1) ? RATE_MAX : RATE_MIN;
			1, 2, 3, 4: rate = $urandom;
			default: rate = int'($urandom_range(0, 4096)) - 2048;
		endcase
		case ($urandom_range(0, 9))
			0, 1: dem = $urandom_range(0, 1) ? DEM_MAX : DEM_MIN;
			2, 3: dem = int'($urandom_range(0, 2000)) - 1000;
			default: dem = $urandom;
		endcase
		r = make_step(tgt, hdg, rate, dem);
		if ($urandom_range(0, 99) < 3)
			r.kind = KIND_CLEAR;
		return r;
	endfunction

	function automatic logic [CFG_W-1:0] random_gain(input logic [CFG_W-1:0] nominal);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4, 5: return nominal + 16'($urandom_range(0, 1023)) - 16'd512;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic cfg_t random_gains();
		cfg_t g;
		g.p_gain = random_gain(P_GAIN_RST);
		g.i_gain = random_gain(I_GAIN_RST);
		g.d_gain = random_gain(D_GAIN_RST);
		g.loop_scale = random_gain(LOOP_SCALE_RST);
		g.smoothing_gain = random_gain(SMOOTHING_RST);
		return g;
	endfunction

	// Present one request, hold it until accepted, then queue its command.
	// Valid stays high on return; the next call either replaces the payload
	// or drops valid, always at the following falling edge.
	task automatic send_request(input req_t r);
		int gap;
		gap = 0;
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
			gap = $urandom_range(1, 8);
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do @(posedge clk); while (req_stall);
		predicted_cmds.push_back(predict_drive(r));
		sent_count++;
		if (r.kind == KIND_CLEAR)
			clear_count++;
	endtask

	task automatic send_random(input int count);
		repeat (count) send_request(random_request());
	endtask

	// Drop valid and wait until every queued command has come back
	task automatic finish_phase();
		@(negedge clk);
		req_valid <= 1'b0;
		while (predicted_cmds.size() != 0) @(posedge clk);
	endtask

	// Write one register; mirror it in the model at the same edge
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			CFG_P_GAIN:     model_gains.p_gain = value;
			CFG_I_GAIN:     model_gains.i_gain = value;
			CFG_D_GAIN:     model_gains.d_gain = value;
			CFG_LOOP_SCALE: model_gains.loop_scale = value;
			CFG_SMOOTHING:  model_gains.smoothing_gain = value;
			default: ;
		endcase
		write_count++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_gains(input cfg_t g);
		write_reg(CFG_P_GAIN, g.p_gain);
		write_reg(CFG_I_GAIN, g.i_gain);
		write_reg(CFG_D_GAIN, g.d_gain);
		write_reg(CFG_LOOP_SCALE, g.loop_scale);
		write_reg(CFG_SMOOTHING, g.smoothing_gain);
	endtask

	// Reset gains: field extremes, both half-turn edges, multi-turn headings, clear
	task automatic test_defaults();
		idle_pct = 15;
		send_request(make_step(0, 0, 0, 0));
		send_request(make_step(ANG_MAX, ANG_MIN, 0, 0));
		send_request(make_step(ANG_MIN, ANG_MAX, 0, 0));
		send_request(make_step(0, 46080, 0, 0));        // minus half turn wraps to plus
		send_request(make_step(46080, 0, 0, 0));        // plus half turn stays
		send_request(make_step(0, -46081, 0, 0));       // just past half turn wraps negative
		send_request(make_step(0, 0, RATE_MAX, 0));
		send_request(make_step(0, 0, RATE_MIN, 0));
		send_request(make_step(0, 0, 0, DEM_MAX));
		send_request(make_step(0, 0, 0, DEM_MAX));
		send_request(make_step(0, 0, 0, DEM_MIN));
		send_request(make_step(1280, 1280 + 10 * 92160, 0, 0));
		send_request(make_clear());
		send_request(make_step(ANG_MAX, 0, RATE_MIN, DEM_MIN));
		send_request(make_step(-1, 0, -1, -1));
		finish_phase();
	endtask

	// All gains at full scale, then all at zero
	task automatic test_gain_extremes();
		idle_pct = 20;
		load_gains('1);
		send_request(make_step(46080, 0, RATE_MIN, DEM_MAX));  // turn and right saturate high
		send_request(make_step(0, 46079, RATE_MAX, DEM_MIN));  // turn saturates low
		send_request(make_step(0, 46079, RATE_MAX, DEM_MAX));
		send_request(make_clear());
		send_random(120);
		finish_phase();
		load_gains('0);
		send_random(80);
		finish_phase();
	endtask

	// Writes past the register map must leave every gain alone
	task automatic test_spare_index();
		idle_pct = 10;
		load_gains(random_gains());
		for (int k = IDX_SPARE_FIRST; k <= IDX_SPARE_LAST; k++)
			write_reg(CFG_IDX_W'(k), 16'($urandom));
		send_random(60);
		finish_phase();
	endtask

	// Bulk of the run: random gain sets, idle rate and error drift per phase
	task automatic test_random_gains();
		for (int ph = 0; ph < GAIN_PHASES; ph++) begin
			case ($urandom_range(0, 3))
				0: idle_pct = 0;
				1: idle_pct = 10;
				2: idle_pct = 25;
				default: idle_pct = 50;
			endcase
			drift_sign = $urandom_range(0, 1) ? 1 : -1;
			load_gains(random_gains());
			send_random(PHASE_ITEMS);
			finish_phase();
		end
	endtask

	// Back to reset gains and full throughput, no idling on either side
	task automatic test_steady_flow();
		idle_pct = 0;
		load_gains('{P_GAIN_RST, I_GAIN_RST, D_GAIN_RST, LOOP_SCALE_RST, SMOOTHING_RST});
		send_random(200);
		finish_phase();
	endtask

	// Result side: random stall bursts, drawn at the idle rate
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			stall_left = $urandom_range(0, 7);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Check every accepted result against the oldest queued command
	always @(posedge clk) begin : check_cmd
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (predicted_cmds.size() == 0) begin
				$error("result with nothing outstanding: left %0d right %0d turn %0d",
					rsp_data.left_drive, rsp_data.right_drive, rsp_data.turn_power);
				fail_count++;
			end else begin
				want = predicted_cmds.pop_front();
				checked_count++;
				if (rsp_data.left_drive !== want.left_drive) begin
					$error("left_drive: expected %0d, got %0d",
						want.left_drive, rsp_data.left_drive);
					fail_count++;
				end
				if (rsp_data.right_drive !== want.right_drive) begin
					$error("right_drive: expected %0d, got %0d",
						want.right_drive, rsp_data.right_drive);
					fail_count++;
				end
				if (rsp_data.turn_power !== want.turn_power) begin
					$error("turn_power: expected %0d, got %0d",
						want.turn_power, rsp_data.turn_power);
					fail_count++;
				end
			end
		end
	end

	initial begin
		// Hold reset from time zero, release at a falling edge
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		test_defaults();
		test_gain_extremes();
		test_spare_index();
		test_random_gains();
		test_steady_flow();

		// Queue is empty; let any stray result show up before closing
		repeat (60) @(posedge clk);
		if (predicted_cmds.size() != 0) begin
			$error("%0d commands never came back", predicted_cmds.size());
			fail_count++;
		end
		$display("Run covered %0d requests (%0d clears) and %0d register writes,",
			sent_count, clear_count, write_count);
		$display("with %0d results compared; %0d field mismatches.", checked_count, fail_count);
		if (fail_count == 0) begin
			$display("[heading_hold_pid_drive] OK");
		end else begin
			$display("[heading_hold_pid_drive] ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/hhpd_pkg.sv
hw/rtl/hhpd_ctrl.sv
hw/rtl/hhpd_wrap.sv
hw/rtl/hhpd_dp.sv
hw/rtl/heading_hold_pid_drive.sv
dv/heading_hold_pid_drive_tb.sv
